/* sv/packet_loss_classifier_defines.svh */
// Assertion macros shared by the packet loss classifier RTL.
// Files that check their own logic include this header; it needs nothing else.
// Every macro assumes a clk_i clock in scope; PLC_ASSERT also assumes an active-low rst_ni reset.
`ifndef PACKET_LOSS_CLASSIFIER_DEFINES_SVH
`define PACKET_LOSS_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS
`define PLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define PLC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define PLC_ASSERT(lbl, prop, msg)
`define PLC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* sv/plc_pkg.sv */
// Types and constants of the packet loss classifier.
// Used by the register file, controller, datapath and top level; no dependencies.
package plc_pkg;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes of the configuration port.
  localparam logic [CFG_ADDR_W-1:0] CFG_BIAZ_UPPER_LIMIT = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPIKE_ALPHA      = 4'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPIKE_BETA       = 4'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_ZIGZAG_ALPHA     = 4'd3;

  localparam logic [9:0]  BIAZ_UPPER_LIMIT_RST = 10'd320;
  localparam logic [15:0] SPIKE_ALPHA_RST      = 16'd32768;
  localparam logic [15:0] SPIKE_BETA_RST       = 16'd21845;
  localparam logic [14:0] ZIGZAG_ALPHA_RST     = 15'd2048;

  // Verdict codes.
  localparam logic [1:0] V_NONE       = 2'd0;
  localparam logic [1:0] V_WIRELESS   = 2'd1;
  localparam logic [1:0] V_CONGESTION = 2'd2;

  // Link state codes.
  localparam logic [2:0] LS_UNDERUSED      = 3'd0;
  localparam logic [2:0] LS_USED_UNSHARED  = 3'd1;
  localparam logic [2:0] LS_AMBIGUOUS      = 3'd2;
  localparam logic [2:0] LS_COMPETING      = 3'd3;

  typedef struct packed {
    logic [31:0]        seq_id;
    logic [31:0]        inter_arrival;
    logic [31:0]        min_inter_arrival;
    logic signed [31:0] curr_rott;
    logic signed [31:0] min_rott;
    logic signed [31:0] max_rott;
    logic [2:0]         link_state;
  } plc_in_t;

  typedef struct packed {
    logic [1:0] loss_verdict;
    logic [1:0] biaz_verdict;
    logic [1:0] spike_verdict;
    logic [1:0] zigzag_verdict;
    logic       spiking_now;
  } plc_out_t;

  typedef struct packed {
    logic [9:0]  biaz_upper_limit;
    logic [15:0] spike_alpha;
    logic [15:0] spike_beta;
    logic [14:0] zigzag_alpha;
  } plc_cfg_t;

  // Operand selection of the two shared multipliers.
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_AVG,
    MUL_SPIKE_GAP,
    MUL_BIAZ,
    MUL_DEV
  } mul_op_e;

  typedef struct packed {
    logic    capture;
    logic    prep;
    mul_op_e mul_op;
    logic    combine;
    logic    avg_upd;
    logic    biaz;
    logic    abs_dev;
    logic    dev_diff;
    logic    dev_upd;
    logic    finish;
  } plc_cmd_t;

  typedef struct packed {
    logic out_free;
  } plc_status_t;

endpackage

/* sv/plc_cfg_regs.sv */
// Configuration register file of the packet loss classifier.
// Depends on plc_pkg for the register indexes, reset values and plc_cfg_t.
module plc_cfg_regs
  import plc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output plc_cfg_t              cfg_o
);

  plc_cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        CFG_BIAZ_UPPER_LIMIT: cfg_d.biaz_upper_limit = cfg_data_i[9:0];
        CFG_SPIKE_ALPHA:      cfg_d.spike_alpha      = cfg_data_i[15:0];
        CFG_SPIKE_BETA:       cfg_d.spike_beta       = cfg_data_i[15:0];
        CFG_ZIGZAG_ALPHA:     cfg_d.zigzag_alpha     = cfg_data_i[14:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.biaz_upper_limit <= BIAZ_UPPER_LIMIT_RST;
      cfg_q.spike_alpha      <= SPIKE_ALPHA_RST;
      cfg_q.spike_beta       <= SPIKE_BETA_RST;
      cfg_q.zigzag_alpha     <= ZIGZAG_ALPHA_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/plc_ctrl.sv */
// Sequencer of the packet loss classifier: walks one word through the datapath.
// Depends on plc_pkg for the command and status structs.
`include "packet_loss_classifier_defines.svh"
module plc_ctrl
  import plc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  plc_status_t status_i,
  output plc_cmd_t    cmd_o
);

  typedef enum logic [11:0] {
    ST_IDLE     = 12'b0000_0000_0001,
    ST_PREP     = 12'b0000_0000_0010,
    ST_EMA_MUL  = 12'b0000_0000_0100,
    ST_EMA_SUM  = 12'b0000_0000_1000,
    ST_AVG_UPD  = 12'b0000_0001_0000,
    ST_BIAZ     = 12'b0000_0010_0000,
    ST_ABS      = 12'b0000_0100_0000,
    ST_DEV_DIFF = 12'b0000_1000_0000,
    ST_DEV_MUL  = 12'b0001_0000_0000,
    ST_DEV_SUM  = 12'b0010_0000_0000,
    ST_DEV_UPD  = 12'b0100_0000_0000,
    ST_FINISH   = 12'b1000_0000_0000
  } state_e;

  state_e state_d, state_q;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) state_d = ST_PREP;
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_EMA_MUL;
      end
      ST_EMA_MUL: begin
        cmd_o.mul_op = MUL_AVG;
        state_d      = ST_EMA_SUM;
      end
      ST_EMA_SUM: begin
        cmd_o.combine = 1'b1;
        cmd_o.mul_op  = MUL_SPIKE_GAP;
        state_d       = ST_AVG_UPD;
      end
      ST_AVG_UPD: begin
        cmd_o.avg_upd = 1'b1;
        cmd_o.mul_op  = MUL_BIAZ;
        state_d       = ST_BIAZ;
      end
      ST_BIAZ: begin
        cmd_o.biaz = 1'b1;
        state_d    = ST_ABS;
      end
      ST_ABS: begin
        cmd_o.abs_dev = 1'b1;
        state_d       = ST_DEV_DIFF;
      end
      ST_DEV_DIFF: begin
        cmd_o.dev_diff = 1'b1;
        state_d        = ST_DEV_MUL;
      end
      ST_DEV_MUL: begin
        cmd_o.mul_op = MUL_DEV;
        state_d      = ST_DEV_SUM;
      end
      ST_DEV_SUM: begin
        cmd_o.combine = 1'b1;
        state_d       = ST_DEV_UPD;
      end
      ST_DEV_UPD: begin
        cmd_o.dev_upd = 1'b1;
        state_d       = ST_FINISH;
      end
      ST_FINISH: begin
        // Hold here while the previous result still sits in the output register.
        cmd_o.finish = status_i.out_free;
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `PLC_ASSERT(a_finish_free, cmd_o.finish |-> status_i.out_free, "result overwrites a pending one")
  `PLC_ASSERT(a_accept_prep, (in_valid_i && in_ready_o) |=> cmd_o.prep, "no prep after accept")
  `PLC_ASSERT_ALWAYS(a_ready_no_cmd, in_ready_o |-> !cmd_o.finish && !cmd_o.prep, "busy cmd in idle")

endmodule

/* sv/plc_datapath.sv */
// Datapath of the packet loss classifier: classifier state, two shared
// multipliers, the averaging steps, the verdict logic and the output register.
// Depends on plc_pkg for the payload, configuration, command and status types.
`include "packet_loss_classifier_defines.svh"
module plc_datapath
  import plc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  plc_cfg_t    cfg_i,
  input  plc_in_t     in_data_i,
  input  plc_cmd_t    cmd_i,
  output plc_status_t status_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output plc_out_t    out_data_o
);

  // Classifier state.
  logic               seen_first_q;
  logic [31:0]        last_seq_q;
  logic               spike_active_q, spike_active_d;
  logic signed [47:0] avg_q, avg_d;
  logic [47:0]        dev_q, dev_d;
  logic               out_valid_q;

  // Per-word working registers.
  plc_in_t            in_q;
  logic               first_q;
  logic [31:0]        gap_q;
  logic signed [32:0] range_q;
  logic signed [32:0] rel_q;
  logic signed [48:0] diff_q, diff_d;
  logic signed [65:0] p0_q, p1_q;
  logic signed [65:0] t_q;
  logic [63:0]        gm_q;
  logic [47:0]        s_q;
  logic               biaz_wl_q;
  plc_out_t           out_q, out_d;

  logic signed [47:0] x_val;
  assign x_val = {in_q.curr_rott, 16'b0};

  // Shared multipliers.
  logic signed [32:0] m0_a, m0_b, m1_a, m1_b;
  logic signed [65:0] prod0, prod1;
  logic [15:0]        weight;
  logic [15:0]        coef;

  always_comb begin
    weight = (cmd_i.mul_op == MUL_DEV) ? {cfg_i.zigzag_alpha, 1'b0}
                                       : {1'b0, cfg_i.zigzag_alpha};
    coef   = spike_active_q ? cfg_i.spike_beta : cfg_i.spike_alpha;
    m0_a = '0;
    m0_b = '0;
    m1_a = '0;
    m1_b = '0;
    case (cmd_i.mul_op)
      MUL_AVG, MUL_DEV: begin
        // The signed difference is split into an unsigned low word and a signed high part.
        m0_a = $signed({1'b0, diff_q[31:0]});
        m0_b = $signed({17'b0, weight});
        m1_a = $signed({{16{diff_q[48]}}, diff_q[48:32]});
        m1_b = $signed({17'b0, weight});
      end
      MUL_SPIKE_GAP: begin
        m0_a = $signed({17'b0, coef});
        m0_b = range_q;
        m1_a = $signed({1'b0, gap_q});
        m1_b = $signed({1'b0, in_q.min_inter_arrival});
      end
      MUL_BIAZ: begin
        m0_a = $signed({23'b0, cfg_i.biaz_upper_limit});
        m0_b = $signed({1'b0, in_q.min_inter_arrival});
      end
      default: begin
        m0_a = '0;
      end
    endcase
  end

  assign prod0 = m0_a * m0_b;
  assign prod1 = m1_a * m1_b;

  // Rebuilt product plus the rounding offset: half for a positive difference and just
  // under half for a negative one, so that the arithmetic shift rounds ties away from zero.
  logic signed [65:0] t_d;
  logic [15:0]        rnd;
  assign rnd = diff_q[48] ? 16'h7FFF : 16'h8000;
  assign t_d = $signed({p1_q[33:0], 32'b0}) + p0_q + $signed({50'b0, rnd});

  // Spike hysteresis against the registered threshold product.
  logic signed [65:0] rel_ext;
  assign rel_ext = $signed({{17{rel_q[32]}}, rel_q, 16'b0});
  assign spike_active_d = spike_active_q ? !(rel_ext < p0_q) : (rel_ext > p0_q);

  assign avg_d = first_q ? x_val : avg_q + t_q[63:16];
  assign dev_d = first_q ? s_q : dev_q + t_q[63:16];

  // Biaz window. The upper bound wraps at 64 bits in the same way as a 64-bit
  // unsigned evaluation would.
  logic [64:0] biaz_lower;
  logic [63:0] biaz_upper;
  logic [63:0] ia_scaled;
  logic        biaz_wl_d;
  assign biaz_lower = {1'b0, gm_q} + {33'b0, in_q.min_inter_arrival};
  assign biaz_upper = {gm_q[55:0], 8'b0} + {22'b0, p0_q[41:0]};
  assign ia_scaled  = {24'b0, in_q.inter_arrival, 8'b0};
  assign biaz_wl_d  = ({33'b0, in_q.inter_arrival} >= biaz_lower) && (ia_scaled < biaz_upper);

  logic signed [48:0] neg_diff;
  assign neg_diff = -diff_q;

  always_comb begin
    diff_d = diff_q;
    if (cmd_i.prep) begin
      diff_d = $signed({x_val[47], x_val}) - $signed({avg_q[47], avg_q});
    end else if (cmd_i.biaz) begin
      diff_d = $signed({x_val[47], x_val}) - $signed({avg_q[47], avg_q});
    end else if (cmd_i.dev_diff) begin
      diff_d = $signed({1'b0, s_q}) - $signed({1'b0, dev_q});
    end
  end

  // ZigZag thresholds and final verdict.
  logic signed [49:0] zz_thr1, x_ext1;
  logic signed [50:0] zz_thr2, x_ext2;
  logic               zz_wl, gap_zero, gap_short;
  logic [1:0]         vb, vs, vz;

  always_comb begin
    x_ext1    = $signed({{2{x_val[47]}}, x_val});
    zz_thr1   = $signed({{2{avg_q[47]}}, avg_q}) - $signed({2'b0, dev_q});
    x_ext2    = $signed({{2{x_val[47]}}, x_val, 1'b0});
    zz_thr2   = $signed({{2{avg_q[47]}}, avg_q, 1'b0}) - $signed({3'b0, dev_q});
    gap_zero  = (gap_q == 32'd0);
    gap_short = (gap_q == 32'd1) || (gap_q == 32'd3);
    zz_wl     = gap_short ? (x_ext1 < zz_thr1) : (x_ext2 < zz_thr2);
    if (gap_zero) begin
      vb = V_NONE;
      vs = V_NONE;
      vz = V_NONE;
    end else begin
      vb = biaz_wl_q ? V_WIRELESS : V_CONGESTION;
      vs = spike_active_q ? V_CONGESTION : V_WIRELESS;
      vz = zz_wl ? V_WIRELESS : V_CONGESTION;
    end
    out_d.biaz_verdict   = vb;
    out_d.spike_verdict  = vs;
    out_d.zigzag_verdict = vz;
    out_d.spiking_now    = spike_active_q;
    case (in_q.link_state) inside
      LS_UNDERUSED, LS_COMPETING: out_d.loss_verdict = vs;
      LS_USED_UNSHARED:           out_d.loss_verdict = vb;
      default:                    out_d.loss_verdict = vz;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_first_q   <= 1'b0;
      last_seq_q     <= '0;
      spike_active_q <= 1'b0;
      avg_q          <= '0;
      dev_q          <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cmd_i.prep) begin
        seen_first_q <= 1'b1;
        last_seq_q   <= in_q.seq_id;
      end
      if (cmd_i.avg_upd) begin
        avg_q          <= avg_d;
        spike_active_q <= spike_active_d;
      end
      if (cmd_i.dev_upd) dev_q <= dev_d;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q    <= in_data_i;
      first_q <= !seen_first_q;
    end
    if (cmd_i.prep) begin
      gap_q   <= first_q ? 32'd0 : in_q.seq_id - last_seq_q - 32'd1;
      range_q <= $signed({in_q.max_rott[31], in_q.max_rott})
               - $signed({in_q.min_rott[31], in_q.min_rott});
      rel_q   <= $signed({in_q.curr_rott[31], in_q.curr_rott})
               - $signed({in_q.min_rott[31], in_q.min_rott});
    end
    diff_q <= diff_d;
    if (cmd_i.mul_op != MUL_NONE) begin
      p0_q <= prod0;
      p1_q <= prod1;
    end
    if (cmd_i.combine) t_q <= t_d;
    if (cmd_i.avg_upd) gm_q <= p1_q[63:0];
    if (cmd_i.biaz) biaz_wl_q <= biaz_wl_d;
    if (cmd_i.abs_dev) s_q <= diff_q[48] ? neg_diff[47:0] : diff_q[47:0];
    if (cmd_i.finish) out_q <= out_d;
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

  `PLC_ASSERT(a_first_marked, cmd_i.capture |-> ##2 seen_first_q, "first packet not recorded")
  `PLC_ASSERT(a_gap_zero_none, (cmd_i.finish && gap_q == 32'd0) |=> (out_q.biaz_verdict == V_NONE && out_q.spike_verdict == V_NONE && out_q.zigzag_verdict == V_NONE), "verdict on zero gap")
  `PLC_ASSERT(a_finish_sets_valid, cmd_i.finish |=> out_valid_q, "result not presented")

endmodule

/* sv/packet_loss_classifier.sv */
// Top level of the packet loss classifier: register file, sequencer and datapath.
// Depends on plc_pkg, plc_cfg_regs, plc_ctrl and plc_datapath.
//
// Each accepted packet word yields exactly one result word carrying the selected
// loss verdict, the Biaz, Spike and ZigZag verdicts, and the spike state after the
// packet. The block cannot accept the next word until it is through with the last one:
// after the accept cycle the sequencer steps through eleven datapath stages, a number set
// by the chain of dependent multiplies through the two shared 33 x 33
// multipliers (average step, spike threshold and gap product, Biaz bound, deviation
// step) with a register after each multiply and each wide add. A finished result
// waits in the output register while the next word is processed; the block stalls
// only if that result is still untaken when the next one is ready. Configuration
// writes are always taken and should only be issued while the block is idle.
module packet_loss_classifier
  import plc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  plc_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output plc_out_t              out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  plc_cfg_t    cfg;
  plc_cmd_t    cmd;
  plc_status_t status;

  assign cfg_ready_o = 1'b1;

  plc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  plc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  plc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

/* tb/testbench.sv */
// Self-checking testbench for packet_loss_classifier: a directed table of packets, then
// random streams under several register settings, checked by a predictor or typed verdicts.
// Depends on plc_pkg and the packet_loss_classifier RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import plc_pkg::*;

  localparam int CYCLE_LIMIT     = 300000;
  localparam int SETTLE_CYCLES   = 16;
  localparam int WORDS_PER_PHASE = 140;
  localparam int NUM_PHASES      = 5;
  localparam int MAX_REPORTS     = 10;

  // Link states without a name in the package; all of them select ZigZag.
  localparam logic [2:0] LS_OTHER   = 3'd4;
  localparam logic [2:0] LS_SPARE_5 = 3'd5;
  localparam logic [2:0] LS_SPARE_6 = 3'd6;
  localparam logic [2:0] LS_SPARE_7 = 3'd7;

  typedef struct packed {
    plc_in_t  pkt;
    logic     typed;
    plc_out_t verdict;
  } probe_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  plc_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  plc_out_t              out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Verdict typed into the table for the word now offered, if any.
  logic     probe_typed = 1'b0;
  plc_out_t probe_verdict = '0;

  // Register copies and classifier state of the predictor.
  bit [9:0]  biaz_limit = BIAZ_UPPER_LIMIT_RST;
  bit [15:0] enter_frac = SPIKE_ALPHA_RST;
  bit [15:0] leave_frac = SPIKE_BETA_RST;
  bit [14:0] ema_weight = ZIGZAG_ALPHA_RST;
  bit        have_first = 1'b0;
  bit [31:0] prev_seq = '0;
  bit        spiking = 1'b0;
  longint    rott_avg = 0;
  bit [63:0] rott_dev = '0;

  plc_out_t    pending_verdicts[$];
  probe_t      probe_table[$];
  int          verdict_errors = 0;
  int          results_seen = 0;
  int unsigned cycle_count = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          stall_left = 0;
  bit [31:0]   seq_cursor = '0;
  int          rott_base = 0;
  int          rott_span = 1000;

  packet_loss_classifier DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_addr_i  (cfg_addr),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Magnitude times a Q0.16 weight, rounded to nearest with ties away from zero.
  function automatic bit [63:0] round_q16(bit [63:0] mag, bit [63:0] w);
    bit [63:0] p;
    p = mag * w;
    return (p >> 16) + ((p >> 15) & 64'd1);
  endfunction

  function automatic void apply_register(logic [CFG_ADDR_W-1:0] addr,
                                         logic [CFG_DATA_W-1:0] data);
    case (addr)
      CFG_BIAZ_UPPER_LIMIT: biaz_limit = data[9:0];
      CFG_SPIKE_ALPHA:      enter_frac = data[15:0];
      CFG_SPIKE_BETA:       leave_frac = data[15:0];
      CFG_ZIGZAG_ALPHA:     ema_weight = data[14:0];
      default: ;
    endcase
  endfunction

  // Advances the classifier state by one packet and returns its verdicts.
  function automatic plc_out_t classify_packet(plc_in_t pkt);
    longint     cur, lo, hi, rng, rel, x, diff, d;
    bit [63:0]  mag, s;
    bit [79:0]  gm, lower, lhs, rhs;
    bit [31:0]  gap;
    bit         first, wl;
    logic [1:0] vb, vs, vz;
    plc_out_t   res;
    cur = $signed(pkt.curr_rott);
    lo = $signed(pkt.min_rott);
    hi = $signed(pkt.max_rott);
    first = !have_first;
    gap = '0;

    // The hysteresis moves on every packet, whatever the gap.
    rng = hi - lo;
    rel = (cur - lo) * 65536;
    if (spiking) begin
      if (rel < longint'(leave_frac) * rng) spiking = 1'b0;
    end else if (rel > longint'(enter_frac) * rng) begin
      spiking = 1'b1;
    end

    x = cur * 65536;
    if (first) begin
      rott_avg = x;
    end else begin
      diff = x - rott_avg;
      mag = (diff < 0) ? -diff : diff;
      if (diff < 0) rott_avg = rott_avg - longint'(round_q16(mag, ema_weight));
      else rott_avg = rott_avg + longint'(round_q16(mag, ema_weight));
    end
    d = x - rott_avg;
    s = (d < 0) ? -d : d;
    if (first) begin
      rott_dev = s;
    end else if (s >= rott_dev) begin
      rott_dev = rott_dev + round_q16(s - rott_dev, {ema_weight, 1'b0});
    end else begin
      rott_dev = rott_dev - round_q16(rott_dev - s, {ema_weight, 1'b0});
    end

    if (!first) gap = pkt.seq_id - prev_seq - 32'd1;
    have_first = 1'b1;
    prev_seq = pkt.seq_id;

    if (gap == 0) begin
      vb = V_NONE;
      vs = V_NONE;
      vz = V_NONE;
    end else begin
      gm = 80'(gap) * 80'(pkt.min_inter_arrival);
      lower = gm + 80'(pkt.min_inter_arrival);
      lhs = 80'(pkt.inter_arrival) << 8;
      rhs = (gm << 8) + 80'(biaz_limit) * 80'(pkt.min_inter_arrival);
      vb = (80'(pkt.inter_arrival) >= lower && lhs < rhs) ? V_WIRELESS : V_CONGESTION;
      vs = spiking ? V_CONGESTION : V_WIRELESS;
      if (gap == 1 || gap == 3) wl = x < rott_avg - longint'(rott_dev);
      else wl = 2 * x < 2 * rott_avg - longint'(rott_dev);
      vz = wl ? V_WIRELESS : V_CONGESTION;
    end

    case (pkt.link_state)
      LS_UNDERUSED, LS_COMPETING: res.loss_verdict = vs;
      LS_USED_UNSHARED:           res.loss_verdict = vb;
      default:                    res.loss_verdict = vz;
    endcase
    res.biaz_verdict = vb;
    res.spike_verdict = vs;
    res.zigzag_verdict = vz;
    res.spiking_now = spiking;
    return res;
  endfunction

  // Mostly a plausible packet stream: small gaps, inter-arrival times near the Biaz
  // window edges and ROTT around a drifting range. A few words are pure noise.
  function automatic plc_in_t random_packet();
    plc_in_t     pkt;
    int          step, cur;
    int unsigned k;
    longint      g, m, lo_b, hi_b, ia;
    if ($urandom_range(49) == 0) begin
      rott_base = int'($urandom_range(200000)) - 100000;
      rott_span = $urandom_range(100000);
    end
    if ($urandom_range(99) < 8) begin
      pkt = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 3'($urandom)};
    end else begin
      k = $urandom_range(99);
      if (k < 45) step = 1;
      else if (k < 65) step = 2;
      else if (k < 75) step = 3;
      else if (k < 85) step = 4;
      else if (k < 89) step = 0;
      else if (k < 94) step = -int'($urandom_range(20, 1));
      else step = $urandom_range(40, 5);
      g = (step >= 1) ? step - 1 : 1;
      m = ($urandom_range(9) == 0) ? 0 : $urandom_range(5000, 1);
      lo_b = (g + 1) * m;
      hi_b = (g * 256 + biaz_limit) * m / 256;
      case ($urandom_range(4))
        0: ia = lo_b - $urandom_range(50, 1);
        1: ia = lo_b;
        2: ia = hi_b - 1 + $urandom_range(2);
        3: ia = lo_b + $urandom_range((hi_b > lo_b) ? hi_b - lo_b : 0);
        default: ia = $urandom;
      endcase
      if (ia < 0) ia = 0;
      if (ia > longint'(32'hFFFF_FFFF)) ia = longint'(32'hFFFF_FFFF);
      pkt.seq_id = seq_cursor + step;
      pkt.inter_arrival = ia[31:0];
      pkt.min_inter_arrival = m[31:0];
      cur = rott_base - rott_span / 4 + int'($urandom_range(rott_span + rott_span / 2));
      pkt.curr_rott = cur;
      if ($urandom_range(19) == 0) begin
        pkt.min_rott = rott_base + rott_span;
        pkt.max_rott = rott_base;
      end else begin
        pkt.min_rott = rott_base - int'($urandom_range(3));
        pkt.max_rott = rott_base + rott_span;
      end
      pkt.link_state = 3'($urandom_range(7));
    end
    seq_cursor = pkt.seq_id;
    return pkt;
  endfunction

  task automatic add_probe(bit [31:0] seq, bit [31:0] ia, bit [31:0] mia, int cur, int mn,
                           int mx, logic [2:0] ls, bit typed, plc_out_t verdict);
    probe_t p;
    p.pkt.seq_id = seq;
    p.pkt.inter_arrival = ia;
    p.pkt.min_inter_arrival = mia;
    p.pkt.curr_rott = cur;
    p.pkt.min_rott = mn;
    p.pkt.max_rott = mx;
    p.pkt.link_state = ls;
    p.typed = typed;
    p.verdict = verdict;
    probe_table.push_back(p);
  endtask

  task automatic send_packet(plc_in_t pkt, logic typed, plc_out_t verdict);
    int gap;
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      gap = $urandom_range(13, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= pkt;
    probe_typed <= typed;
    probe_verdict <= verdict;
    do @(posedge clk); while (!in_ready);
  endtask

  // Holds the sender off until every verdict is back and the block has gone quiet.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_register(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_settings(bit [9:0] upper, bit [15:0] enter, bit [15:0] leave,
                                bit [14:0] weight);
    put_register(CFG_BIAZ_UPPER_LIMIT, CFG_DATA_W'(upper));
    put_register(CFG_SPIKE_ALPHA, CFG_DATA_W'(enter));
    put_register(CFG_SPIKE_BETA, CFG_DATA_W'(leave));
    put_register(CFG_ZIGZAG_ALPHA, CFG_DATA_W'(weight));
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver back-pressure in bursts of random length.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct) begin
      stall_left = $urandom_range(12, 0);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : scoreboard
    plc_out_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) apply_register(cfg_addr, cfg_data);
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_verdicts.size() == 0) begin
          verdict_errors++;
          if (verdict_errors <= MAX_REPORTS)
            $display("result %0d arrived with no word outstanding", results_seen);
        end else begin
          want = pending_verdicts.pop_front();
          if (out_data.loss_verdict !== want.loss_verdict ||
              out_data.biaz_verdict !== want.biaz_verdict ||
              out_data.spike_verdict !== want.spike_verdict ||
              out_data.zigzag_verdict !== want.zigzag_verdict ||
              out_data.spiking_now !== want.spiking_now) begin
            verdict_errors++;
            if (verdict_errors <= MAX_REPORTS)
              $display("result %0d: expected loss %0d biaz %0d spike %0d zigzag %0d %s%0d",
                       results_seen, want.loss_verdict, want.biaz_verdict,
                       want.spike_verdict, want.zigzag_verdict, "spiking ",
                       want.spiking_now,
                       "\n           got      loss %0d biaz %0d spike %0d zigzag %0d %s%0d",
                       out_data.loss_verdict, out_data.biaz_verdict,
                       out_data.spike_verdict, out_data.zigzag_verdict, "spiking ",
                       out_data.spiking_now);
          end
        end
      end
      if (in_valid && in_ready) begin
        want = classify_packet(in_data);
        if (probe_typed) want = probe_verdict;
        pending_verdicts.push_back(want);
      end
    end
  end

  initial begin : stimulus
    int ph;
    int i;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // The first word after reset and any in-order successor carry no loss at all.
    add_probe(32'd100, 32'd0, 32'd0, 0, 0, 100, LS_UNDERUSED, 1'b1,
              {V_NONE, V_NONE, V_NONE, V_NONE, 1'b0});
    add_probe(32'd101, 32'd0, 32'd0, 100, 0, 100, LS_USED_UNSHARED, 1'b1,
              {V_NONE, V_NONE, V_NONE, V_NONE, 1'b1});
    add_probe(32'd103, 32'd200, 32'd100, 100, 0, 100, LS_UNDERUSED, 1'b0, '0);
    add_probe(32'd105, 32'd150, 32'd100, 0, 0, 100, LS_USED_UNSHARED, 1'b0, '0);
    add_probe(32'd109, 32'd400, 32'd100, -1000, 0, 100, LS_AMBIGUOUS, 1'b0, '0);
    add_probe(32'd112, 32'd300, 32'd100, -5000, 0, 100, LS_OTHER, 1'b0, '0);
    // Duplicate, then a reordered word, then an inverted ROTT range.
    add_probe(32'd112, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 50, 0, 100, LS_USED_UNSHARED,
              1'b0, '0);
    add_probe(32'd50, 32'd0, 32'd0, 50, 0, 100, LS_COMPETING, 1'b0, '0);
    add_probe(32'hFFFF_FFFF, 32'd7, 32'd3, 0, 100, -100, LS_UNDERUSED, 1'b0, '0);
    add_probe(32'd0, 32'd1, 32'd1, 200, 100, -100, LS_UNDERUSED, 1'b0, '0);
    add_probe(32'd2, 32'd0, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              LS_SPARE_5, 1'b0, '0);
    add_probe(32'd5, 32'hFFFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              LS_SPARE_6, 1'b0, '0);
    add_probe(32'd9, 32'hFFFF_FFFF, 32'd0, 0, 32'h8000_0000, 32'h7FFF_FFFF,
              LS_SPARE_7, 1'b0, '0);
    // Biaz window edges for a gap of two at the reset upper factor.
    add_probe(32'd12, 32'd3000, 32'd1000, -20, -50, 50, LS_USED_UNSHARED, 1'b0, '0);
    add_probe(32'd15, 32'd3250, 32'd1000, -20, -50, 50, LS_USED_UNSHARED, 1'b0, '0);
    add_probe(32'd18, 32'd3249, 32'd1000, -20, -50, 50, LS_USED_UNSHARED, 1'b0, '0);
    add_probe(32'd19, 32'd5, 32'd5, 10, -50, 50, LS_COMPETING, 1'b0, '0);

    tx_idle_pct = 25;
    rx_idle_pct = 15;
    for (i = 0; i < probe_table.size(); i++)
      send_packet(probe_table[i].pkt, probe_table[i].typed, probe_table[i].verdict);
    seq_cursor = probe_table[probe_table.size() - 1].pkt.seq_id;

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_quiet();
      case (ph)
        0: write_settings(10'd1023, 16'hFFFF, 16'hFFFF, 15'h7FFF);
        1: write_settings(10'd256, 16'h0000, 16'h0000, 15'h0000);
        3: write_settings(BIAZ_UPPER_LIMIT_RST, SPIKE_ALPHA_RST, SPIKE_BETA_RST,
                          ZIGZAG_ALPHA_RST);
        default: write_settings(10'($urandom_range(1023, 256)), 16'($urandom),
                                16'($urandom), 15'($urandom));
      endcase
      case (ph)
        0: begin
          tx_idle_pct = 20;
          rx_idle_pct = 10;
        end
        2: begin
          tx_idle_pct = 45;
          rx_idle_pct = 15;
        end
        3: begin
          tx_idle_pct = 10;
          rx_idle_pct = 20;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      repeat (WORDS_PER_PHASE) send_packet(random_packet(), 1'b0, '0);
    end

    wait_quiet();
    if (verdict_errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
